### src/boiu_pkg.sv
package boiu_pkg;

    localparam int MAX_DIMS_DEF = 4;
    localparam int DIM_BITS_DEF = 16;

    localparam int IDX_W   = 32;
    localparam int SHAPE_W = 64;
    localparam int RANK_W  = 3;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    localparam logic [SHAPE_W-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;
    localparam logic [RANK_W-1:0]  RANK_RESET  = 3'd1;

    localparam logic [2:0] REG_OUT_SHAPE = 3'd0;
    localparam logic [2:0] REG_A_SHAPE   = 3'd1;
    localparam logic [2:0] REG_B_SHAPE   = 3'd2;
    localparam logic [2:0] REG_OUT_RANK  = 3'd3;
    localparam logic [2:0] REG_A_RANK    = 3'd4;
    localparam logic [2:0] REG_B_RANK    = 3'd5;

endpackage

### src/boiu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module boiu_div #(
    parameter int DIM_BITS = boiu_pkg::DIM_BITS_DEF,
    parameter int SIDE_W   = boiu_pkg::MAX_DIMS_DEF * boiu_pkg::DIM_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [boiu_pkg::IDX_W-1:0] in_num,
    input  logic [SIDE_W-1:0]         in_side,
    input  logic [DIM_BITS-1:0]       divisor,
    output logic                      out_valid,
    output logic [boiu_pkg::IDX_W-1:0] out_quot,
    output logic [DIM_BITS-1:0]       out_rem,
    output logic [SIDE_W-1:0]         out_side
);
    localparam int STEPS = boiu_pkg::IDX_W;

    logic                       v_s    [STEPS+1];
    logic [boiu_pkg::IDX_W-1:0] num_s  [STEPS+1];
    logic [DIM_BITS-1:0]        rem_s  [STEPS+1];
    logic [SIDE_W-1:0]          side_s [STEPS+1];

    assign v_s[0]    = in_valid;
    assign num_s[0]  = in_num;
    assign rem_s[0]  = '0;
    assign side_s[0] = in_side;

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic                       valid_reg;
            logic [boiu_pkg::IDX_W-1:0] num_reg;
            logic [DIM_BITS-1:0]        rem_reg;
            logic [SIDE_W-1:0]          side_reg;
            logic [DIM_BITS:0]          trial;
            logic [DIM_BITS:0]          diff;
            logic                       ge;
            logic [boiu_pkg::IDX_W-1:0] num_next;
            logic [DIM_BITS-1:0]        rem_next;

            always_comb
            begin
                trial    = {rem_s[i], num_s[i][boiu_pkg::IDX_W-1]};
                diff     = trial - {1'b0, divisor};
                ge       = (trial >= {1'b0, divisor});
                rem_next = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
                num_next = {num_s[i][boiu_pkg::IDX_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg <= 1'b0;
                else if (en)
                    valid_reg <= v_s[i];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg  <= num_next;
                    rem_reg  <= rem_next;
                    side_reg <= side_s[i];
                end
            end

            assign v_s[i+1]    = valid_reg;
            assign num_s[i+1]  = num_reg;
            assign rem_s[i+1]  = rem_reg;
            assign side_s[i+1] = side_reg;
        end
    endgenerate

    assign out_valid = v_s[STEPS];
    assign out_quot  = num_s[STEPS];
    assign out_rem   = rem_s[STEPS];
    assign out_side  = side_s[STEPS];
endmodule

### src/boiu_cfg.sv
// Register file and per-dimension divisor / stride derivation.
module boiu_cfg #(
    parameter int MAX_DIMS = boiu_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS = boiu_pkg::DIM_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [boiu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [boiu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [boiu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [DIM_BITS-1:0]             divisor  [MAX_DIMS],
    output logic [boiu_pkg::IDX_W-1:0]      a_stride [MAX_DIMS],
    output logic [boiu_pkg::IDX_W-1:0]      b_stride [MAX_DIMS]
);
    logic [boiu_pkg::SHAPE_W-1:0] out_shape_reg, a_shape_reg, b_shape_reg;
    logic [boiu_pkg::RANK_W-1:0]  out_rank_reg, a_rank_reg, b_rank_reg;
    logic [boiu_pkg::RANK_W-1:0]  rr, ra, rb;
    logic [2:0]                   reg_sel;
    logic                         wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[boiu_pkg::APB_ADDR_W-1:3];
    assign wr      = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_shape_reg <= boiu_pkg::SHAPE_RESET;
            a_shape_reg   <= boiu_pkg::SHAPE_RESET;
            b_shape_reg   <= boiu_pkg::SHAPE_RESET;
            out_rank_reg  <= boiu_pkg::RANK_RESET;
            a_rank_reg    <= boiu_pkg::RANK_RESET;
            b_rank_reg    <= boiu_pkg::RANK_RESET;
        end
        else if (wr)
        begin
            case (reg_sel)
                boiu_pkg::REG_OUT_SHAPE: out_shape_reg <= pwdata;
                boiu_pkg::REG_A_SHAPE:   a_shape_reg   <= pwdata;
                boiu_pkg::REG_B_SHAPE:   b_shape_reg   <= pwdata;
                boiu_pkg::REG_OUT_RANK:  out_rank_reg  <= pwdata[boiu_pkg::RANK_W-1:0];
                boiu_pkg::REG_A_RANK:    a_rank_reg    <= pwdata[boiu_pkg::RANK_W-1:0];
                boiu_pkg::REG_B_RANK:    b_rank_reg    <= pwdata[boiu_pkg::RANK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            boiu_pkg::REG_OUT_SHAPE: prdata = out_shape_reg;
            boiu_pkg::REG_A_SHAPE:   prdata = a_shape_reg;
            boiu_pkg::REG_B_SHAPE:   prdata = b_shape_reg;
            boiu_pkg::REG_OUT_RANK:  prdata = boiu_pkg::APB_DATA_W'(out_rank_reg);
            boiu_pkg::REG_A_RANK:    prdata = boiu_pkg::APB_DATA_W'(a_rank_reg);
            boiu_pkg::REG_B_RANK:    prdata = boiu_pkg::APB_DATA_W'(b_rank_reg);
            default:                 prdata = '0;
        endcase
    end

    // ranks above MAX_DIMS count as MAX_DIMS
    localparam logic [boiu_pkg::RANK_W-1:0] RMAX = boiu_pkg::RANK_W'(MAX_DIMS);
    assign rr = (out_rank_reg > RMAX) ? RMAX : out_rank_reg;
    assign ra = (a_rank_reg > RMAX) ? RMAX : a_rank_reg;
    assign rb = (b_rank_reg > RMAX) ? RMAX : b_rank_reg;

    logic [DIM_BITS-1:0]        so [MAX_DIMS];
    logic [DIM_BITS-1:0]        sa [MAX_DIMS];
    logic [DIM_BITS-1:0]        sb [MAX_DIMS];
    logic [boiu_pkg::IDX_W-1:0] run_a [MAX_DIMS];
    logic [boiu_pkg::IDX_W-1:0] run_b [MAX_DIMS];

    genvar d;
    generate
        for (d = 0; d < MAX_DIMS; d++)
        begin : g_dim
            localparam logic [boiu_pkg::RANK_W-1:0] DPOS = boiu_pkg::RANK_W'(d);
            logic [boiu_pkg::IDX_W-1:0] st_a_reg, st_b_reg;

            // dimension d counted from innermost, right-aligned per rank
            always_comb
            begin
                so[d] = '0;
                sa[d] = '0;
                sb[d] = '0;
                for (int k = 0; k < MAX_DIMS; k++)
                begin
                    if (rr == boiu_pkg::RANK_W'(k + d + 1))
                        so[d] = out_shape_reg[k*DIM_BITS +: DIM_BITS];
                    if (ra == boiu_pkg::RANK_W'(k + d + 1))
                        sa[d] = a_shape_reg[k*DIM_BITS +: DIM_BITS];
                    if (rb == boiu_pkg::RANK_W'(k + d + 1))
                        sb[d] = b_shape_reg[k*DIM_BITS +: DIM_BITS];
                end
                if (DPOS >= ra)
                    sa[d] = DIM_BITS'(1);
                if (DPOS >= rb)
                    sb[d] = DIM_BITS'(1);
            end

            // unused or zero-size dims divide by one: coordinate 0, index passes
            assign divisor[d] = (DPOS < rr && so[d] != '0) ? so[d] : DIM_BITS'(1);

            if (d == 0)
            begin : g_first
                assign run_a[d] = boiu_pkg::IDX_W'(1);
                assign run_b[d] = boiu_pkg::IDX_W'(1);
            end
            else
            begin : g_rest
                logic [boiu_pkg::IDX_W-1:0] run_a_reg, run_b_reg;
                always_ff @(posedge clk)
                begin
                    run_a_reg <= boiu_pkg::IDX_W'(run_a[d-1] * boiu_pkg::IDX_W'(sa[d-1]));
                    run_b_reg <= boiu_pkg::IDX_W'(run_b[d-1] * boiu_pkg::IDX_W'(sb[d-1]));
                end
                assign run_a[d] = run_a_reg;
                assign run_b[d] = run_b_reg;
            end

            always_ff @(posedge clk)
            begin
                st_a_reg <= (DPOS < rr && sa[d] == so[d]) ? run_a[d] : '0;
                st_b_reg <= (DPOS < rr && sb[d] == so[d]) ? run_b[d] : '0;
            end

            assign a_stride[d] = st_a_reg;
            assign b_stride[d] = st_b_reg;
        end
    endgenerate
endmodule

### src/boiu_acc.sv
// Coordinate x stride products, then the sum.
module boiu_acc #(
    parameter int MAX_DIMS = boiu_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS = boiu_pkg::DIM_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [MAX_DIMS*DIM_BITS-1:0] pos,
    input  logic [boiu_pkg::IDX_W-1:0]  a_stride [MAX_DIMS],
    input  logic [boiu_pkg::IDX_W-1:0]  b_stride [MAX_DIMS],
    output logic                        out_valid,
    output logic [boiu_pkg::IDX_W-1:0]  a_off,
    output logic [boiu_pkg::IDX_W-1:0]  b_off
);
    logic                       prod_valid_reg, sum_valid_reg;
    logic [boiu_pkg::IDX_W-1:0] prod_a_reg [MAX_DIMS];
    logic [boiu_pkg::IDX_W-1:0] prod_b_reg [MAX_DIMS];
    logic [boiu_pkg::IDX_W-1:0] sum_a_reg, sum_b_reg, sum_a, sum_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_comb
    begin
        sum_a = '0;
        sum_b = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            sum_a = sum_a + prod_a_reg[d];
            sum_b = sum_b + prod_b_reg[d];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                prod_a_reg[d] <= boiu_pkg::IDX_W'(
                    boiu_pkg::IDX_W'(pos[d*DIM_BITS +: DIM_BITS]) * a_stride[d]);
                prod_b_reg[d] <= boiu_pkg::IDX_W'(
                    boiu_pkg::IDX_W'(pos[d*DIM_BITS +: DIM_BITS]) * b_stride[d]);
            end
            sum_a_reg <= sum_a;
            sum_b_reg <= sum_b;
        end
    end

    assign out_valid = sum_valid_reg;
    assign a_off     = sum_a_reg;
    assign b_off     = sum_b_reg;
endmodule

### src/broadcast_operand_index_unit.sv
// Broadcast operand index unit: for every request carrying a linear index into a
// broadcast result tensor it returns the flat element indices into operands A and
// B. One request is accepted per clock while the skid slot is free, and results
// stream out in order at the same rate. Each result dimension peels its coordinate
// off the index in a 32-stage restoring divider, one quotient bit per stage, then
// one stage multiplies coordinates by strides, one sums them and one holds the
// output. A two-entry output (register plus skid) lets the pipeline keep taking
// requests while a result waits; back-pressure freezes the whole pipeline in place.
// Shapes and ranks are written over the APB port (64-bit registers at byte
// addresses 8*i); the user must write them only while no request is in flight,
// as the block itself does not enforce this. Strides are derived from them through
// registered running products, well before any request reaches the multiply stage.
module broadcast_operand_index_unit #(
    parameter int MAX_DIMS = boiu_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS = boiu_pkg::DIM_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [boiu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [boiu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [boiu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] elem_idx
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata    // [31:0] a_offset, [63:32] b_offset
);
    localparam int SIDE_W = MAX_DIMS * DIM_BITS;

    logic [DIM_BITS-1:0]        divisor  [MAX_DIMS];
    logic [boiu_pkg::IDX_W-1:0] a_stride [MAX_DIMS];
    logic [boiu_pkg::IDX_W-1:0] b_stride [MAX_DIMS];

    boiu_cfg #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .divisor  (divisor),
        .a_stride (a_stride),
        .b_stride (b_stride)
    );

    // Pipeline advances whenever the skid slot is free.
    logic en;
    logic skid_valid_reg, out_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Chain of per-dimension dividers, innermost dimension first. The side band
    // collects each dimension's coordinate as it comes out.
    logic                       v_c    [MAX_DIMS+1];
    logic [boiu_pkg::IDX_W-1:0] num_c  [MAX_DIMS+1];
    logic [SIDE_W-1:0]          side_c [MAX_DIMS+1];

    assign v_c[0]    = s_tvalid;
    assign num_c[0]  = s_tdata;
    assign side_c[0] = '0;

    genvar d;
    generate
        for (d = 0; d < MAX_DIMS; d++)
        begin : g_dim
            logic                       dv;
            logic [boiu_pkg::IDX_W-1:0] quot;
            logic [DIM_BITS-1:0]        rem;
            logic [SIDE_W-1:0]          side_o;
            logic [SIDE_W-1:0]          side_mix;

            boiu_div #(
                .DIM_BITS (DIM_BITS),
                .SIDE_W   (SIDE_W)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v_c[d]),
                .in_num    (num_c[d]),
                .in_side   (side_c[d]),
                .divisor   (divisor[d]),
                .out_valid (dv),
                .out_quot  (quot),
                .out_rem   (rem),
                .out_side  (side_o)
            );

            always_comb
            begin
                side_mix                        = side_o;
                side_mix[d*DIM_BITS +: DIM_BITS] = rem;
            end

            assign v_c[d+1]    = dv;
            assign num_c[d+1]  = quot;
            assign side_c[d+1] = side_mix;
        end
    endgenerate

    logic                       acc_valid;
    logic [boiu_pkg::IDX_W-1:0] acc_a, acc_b;

    boiu_acc #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_c[MAX_DIMS]),
        .pos       (side_c[MAX_DIMS]),
        .a_stride  (a_stride),
        .b_stride  (b_stride),
        .out_valid (acc_valid),
        .a_off     (acc_a),
        .b_off     (acc_b)
    );

    // Output register with skid slot.
    logic [63:0] out_data_reg, skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= acc_valid;
        end
        else if (acc_valid && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else
                out_data_reg <= {acc_b, acc_a};
        end
        else if (acc_valid && en)
            skid_data_reg <= {acc_b, acc_a};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // skid slot only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid result lost under back-pressure");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> !skid_valid_reg && out_valid_reg
            && out_data_reg == $past(skid_data_reg))
        else $error("skid result not moved to output");

    a_stall_freezes_end: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> acc_valid == $past(acc_valid))
        else $error("pipeline moved while stalled");
endmodule
